FILE: rtl/egt_pkg.sv
package egt_pkg;

  localparam int unsigned AddrWidth = 64;
  localparam int unsigned NodeWidth = 17;
  localparam logic [NodeWidth-1:0] NodeSizeReset = NodeWidth'(16384);

  typedef logic [AddrWidth-1:0] word_t;
  typedef logic [NodeWidth-1:0] node_t;

  typedef enum logic [1:0] {
    OP_DATA   = 2'd0,
    OP_META   = 2'd1,
    OP_HEADER = 2'd2,
    OP_END    = 2'd3
  } op_t;

endpackage

FILE: rtl/egt_rec_if.sv
interface egt_rec_if
  import egt_pkg::*;
();
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  word_t       start_addr;
  word_t       span_len;
  word_t       region_flags;
  word_t       region_used;

  modport source (
    output valid, opcode, start_addr, span_len, region_flags, region_used,
    input  ready
  );
  modport sink (
    input  valid, opcode, start_addr, span_len, region_flags, region_used,
    output ready
  );
endinterface

FILE: rtl/egt_sum_if.sv
interface egt_sum_if
  import egt_pkg::*;
();
  logic  valid;
  logic  ready;
  word_t out_flags;
  word_t out_start;
  word_t out_length;
  word_t out_used;
  word_t extent_total;
  word_t largest_gap;

  modport source (
    output valid, out_flags, out_start, out_length, out_used, extent_total, largest_gap,
    input  ready
  );
  modport sink (
    input  valid, out_flags, out_start, out_length, out_used, extent_total, largest_gap,
    output ready
  );
endinterface

FILE: rtl/egt_cfg_if.sv
interface egt_cfg_if
  import egt_pkg::*;
();
  logic  valid;
  logic  ready;
  node_t data;

  modport source (
    output valid, data,
    input  ready
  );
  modport sink (
    input  valid, data,
    output ready
  );
endinterface

FILE: rtl/extent_gap_tracker.sv
// channel | dir | payload
// --------+-----+-------------------------------------------------------------
// rec     | in  | opcode, start_addr, span_len, region_flags, region_used
// sum     | out | out_flags, out_start, out_length, out_used, extent_total,
//         |     | largest_gap
// cfg     | in  | data: node_size, always ready
//
// one record per cycle unless the output register stalls: a record enters the
// input register, then updates the region state and, when it closes a region,
// loads the summary register, which offers the summary on sum.
// the record stage stalls only while a summary waits in the output register.
// rst is synchronous: region state clears to zero, node_size to 16384.
module extent_gap_tracker
  import egt_pkg::*;
(
  input logic      clk,
  input logic      rst,
  egt_rec_if.sink  rec,
  egt_sum_if.source sum,
  egt_cfg_if.sink  cfg
);

  // input register
  logic  s1_valid;
  op_t   s1_op;
  word_t s1_addr;
  word_t s1_len;
  word_t s1_flags;
  word_t s1_used;

  // region state
  node_t node_size;
  logic  region_open;
  word_t held_flags;
  word_t held_start;
  word_t held_length;
  word_t held_used;
  word_t region_end;
  word_t extent_count;
  word_t gap_max;
  word_t gap_begin;

  logic  region_open_next;
  word_t extent_count_next;
  word_t gap_max_next;
  word_t gap_begin_next;

  // output register
  logic  out_valid;
  word_t out_flags;
  word_t out_start;
  word_t out_length;
  word_t out_used;
  word_t out_total;
  word_t out_gap;

  logic  advance;
  logic  emit;
  word_t ext_len;
  word_t tail_gap;
  word_t tail_max;
  word_t mid_gap;

  assign advance   = s1_valid && (!out_valid || sum.ready);
  assign rec.ready = !s1_valid || advance;
  assign cfg.ready = 1'b1;

  assign ext_len  = (s1_op == OP_DATA) ? s1_len : word_t'(node_size);
  assign tail_gap = region_end - gap_begin;
  assign tail_max = (tail_gap > gap_max) ? tail_gap : gap_max;
  assign mid_gap  = s1_addr - gap_begin;

  always_comb begin
    emit              = 1'b0;
    region_open_next  = region_open;
    extent_count_next = extent_count;
    gap_max_next      = gap_max;
    gap_begin_next    = gap_begin;
    case (s1_op)
      OP_DATA, OP_META: begin
        if (region_open && s1_addr >= region_end) begin
          // extent belongs to the next region
          emit              = 1'b1;
          region_open_next  = 1'b0;
          extent_count_next = word_t'(1);
          gap_max_next      = '0;
        end else begin
          extent_count_next = extent_count + word_t'(1);
          if (region_open && mid_gap > gap_max) begin
            gap_max_next = mid_gap;
          end
        end
        gap_begin_next = s1_addr + ext_len;
      end
      OP_HEADER: begin
        if (region_open) begin
          emit              = 1'b1;
          extent_count_next = '0;
          gap_max_next      = '0;
        end
        region_open_next = 1'b1;
        if (s1_addr > gap_begin) begin
          gap_begin_next = s1_addr;
        end
      end
      default: begin
        emit              = region_open;
        region_open_next  = 1'b0;
        extent_count_next = '0;
        gap_max_next      = '0;
        gap_begin_next    = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      out_valid    <= 1'b0;
      node_size    <= NodeSizeReset;
      region_open  <= 1'b0;
      held_flags   <= '0;
      held_start   <= '0;
      held_length  <= '0;
      held_used    <= '0;
      region_end   <= '0;
      extent_count <= '0;
      gap_max      <= '0;
      gap_begin    <= '0;
    end else begin
      if (cfg.valid) begin
        node_size <= cfg.data;
      end

      if (rec.valid && rec.ready) begin
        s1_valid <= 1'b1;
        s1_op    <= op_t'(rec.opcode);
        s1_addr  <= rec.start_addr;
        s1_len   <= rec.span_len;
        s1_flags <= rec.region_flags;
        s1_used  <= rec.region_used;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end

      if (advance) begin
        region_open  <= region_open_next;
        extent_count <= extent_count_next;
        gap_max      <= gap_max_next;
        gap_begin    <= gap_begin_next;
        if (s1_op == OP_HEADER) begin
          held_flags  <= s1_flags;
          held_start  <= s1_addr;
          held_length <= s1_len;
          held_used   <= s1_used;
          region_end  <= s1_addr + s1_len;
        end else if (s1_op == OP_END) begin
          held_flags  <= '0;
          held_start  <= '0;
          held_length <= '0;
          held_used   <= '0;
          region_end  <= '0;
        end
      end

      if (advance && emit) begin
        out_valid  <= 1'b1;
        out_flags  <= held_flags;
        out_start  <= held_start;
        out_length <= held_length;
        out_used   <= held_used;
        out_total  <= extent_count;
        out_gap    <= tail_max;
      end else if (sum.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign sum.valid        = out_valid;
  assign sum.out_flags    = out_flags;
  assign sum.out_start    = out_start;
  assign sum.out_length   = out_length;
  assign sum.out_used     = out_used;
  assign sum.extent_total = out_total;
  assign sum.largest_gap  = out_gap;

endmodule
